[design/swtq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swtq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int THREAD_COUNT = 16;
   localparam int TICK_BITS    = 32;

   // Field widths of the stream beats
   localparam int ID_W        = 4;
   localparam int ID_COUNT    = 2 ** ID_W;
   localparam int MASK_W      = 16;
   localparam int TICK_FLD_W  = 32;
   localparam int COUNT_FLD_W = 5;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [TICK_BITS-1:0] tick_type;
   typedef logic [ID_W-1:0]      id_type;
   typedef logic [MASK_W-1:0]    mask_type;

   typedef enum logic {
      CMD_SLEEP = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_SLEEP   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DEAD   = 2'd1,
      STATUS_QUEUED = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      id_type   thread;
      tick_type wake;
   } slot_type;

   typedef struct packed {
      cmd_type                 cmd;
      id_type                  thread_id;
      logic [TICK_FLD_W-1:0]   tick_value;
      mask_type                alive_mask;
   } req_type;

   typedef struct packed {
      kind_type                kind;
      status_type              status;
      id_type                  released_thread;
      logic                    released_valid;
      logic                    last;
      logic [COUNT_FLD_W-1:0]  count;
      logic                    is_empty;
      logic [TICK_FLD_W-1:0]   earliest_wake;
   } rsp_type;

   // Physical slot of logical position offset in the circular queue
   function automatic idx_type slot_index(idx_type base, cnt_type offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return IDX_W'(sum);
   endfunction

   function automatic logic thread_alive(id_type id, mask_type mask);
      return (int'(id) < THREAD_COUNT) && mask[id];
   endfunction

endpackage

`default_nettype wire

[design/swtq_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module swtq_engine (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire swtq_pkg::req_type req_item,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output swtq_pkg::rsp_type   rsp_item
);
   import swtq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_RD,
      ST_INS_CMP,
      ST_POP_RD,
      ST_POP_CMP,
      ST_POP_END,
      ST_REL_RD,
      ST_REL_CHK,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   id_type     tid_ff, tid_in;
   tick_type   tick_ff, tick_in;
   mask_type   alive_ff, alive_in;
   cnt_type    occ_ff, occ_in;
   idx_type    head_ff, head_in;
   idx_type    base_ff, base_in;
   tick_type   head_wake_ff, head_wake_in;
   logic [ID_COUNT-1:0] queued_ff, queued_in;
   cnt_type    scan_ff, scan_in;
   cnt_type    last_live_ff, last_live_in;
   logic       live_any_ff, live_any_in;
   status_type status_ff, status_in;

   // slot store: one write and one registered read per cycle
   slot_type   slot_mem [QUEUE_DEPTH];
   slot_type   rd_data_ff;
   logic       rd_en;
   idx_type    rd_addr;
   logic       wr_en;
   idx_type    wr_addr;
   slot_type   wr_data;

   logic       rd_due;
   logic       rd_alive;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_due   = (rd_data_ff.wake <= tick_ff);
   assign rd_alive = thread_alive(rd_data_ff.thread, alive_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tid_in       = tid_ff;
      tick_in      = tick_ff;
      alive_in     = alive_ff;
      occ_in       = occ_ff;
      head_in      = head_ff;
      base_in      = base_ff;
      head_wake_in = head_wake_ff;
      queued_in    = queued_ff;
      scan_in      = scan_ff;
      last_live_in = last_live_ff;
      live_any_in  = live_any_ff;
      status_in    = status_ff;
      rd_en        = 1'b0;
      rd_addr      = slot_index(head_ff, scan_ff);
      wr_en        = 1'b0;
      wr_addr      = slot_index(head_ff, scan_ff);
      wr_data      = '{thread: tid_ff, wake: tick_ff};
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = 1'b0;

      rsp_item.kind            = (cmd_ff == CMD_TICK) ? KIND_RELEASE : KIND_SLEEP;
      rsp_item.status          = status_ff;
      rsp_item.released_thread = '0;
      rsp_item.released_valid  = 1'b0;
      rsp_item.last            = 1'b1;
      rsp_item.count           = COUNT_FLD_W'(occ_ff);
      rsp_item.is_empty        = (occ_ff == '0);
      rsp_item.earliest_wake   = (occ_ff == '0) ? '0 : TICK_FLD_W'(head_wake_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_item.cmd;
               tid_in   = req_item.thread_id;
               tick_in  = TICK_BITS'(req_item.tick_value);
               alive_in = req_item.alive_mask;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cmd_ff == CMD_TICK) begin
               status_in   = STATUS_OK;
               scan_in     = '0;
               live_any_in = 1'b0;
               base_in     = head_ff;
               state_in    = ST_POP_RD;
            end else if (!thread_alive(tid_ff, alive_ff)) begin
               status_in = STATUS_DEAD;
               state_in  = ST_EMIT;
            end else if (queued_ff[tid_ff]) begin
               status_in = STATUS_QUEUED;
               state_in  = ST_EMIT;
            end else if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
               status_in = STATUS_FULL;
               state_in  = ST_EMIT;
            end else begin
               status_in = STATUS_OK;
               scan_in   = occ_ff;
               state_in  = ST_INS_RD;
            end
         end
         ST_INS_RD, ST_INS_CMP: begin
            // walk from the tail, moving later entries up one slot
            if ((state_ff == ST_INS_RD && scan_ff == '0)
                || (state_ff == ST_INS_CMP && rd_due)) begin
               wr_en                = 1'b1;
               occ_in               = occ_ff + CNT_W'(1);
               queued_in[tid_ff]    = 1'b1;
               if (scan_ff == '0) begin
                  head_wake_in = tick_ff;
               end
               state_in = ST_EMIT;
            end else if (state_ff == ST_INS_RD) begin
               rd_en    = 1'b1;
               rd_addr  = slot_index(head_ff, scan_ff - CNT_W'(1));
               state_in = ST_INS_CMP;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rd_data_ff;
               scan_in  = scan_ff - CNT_W'(1);
               state_in = ST_INS_RD;
            end
         end
         ST_POP_RD: begin
            if (scan_ff == occ_ff) begin
               state_in = ST_POP_END;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_POP_CMP;
            end
         end
         ST_POP_CMP: begin
            if (rd_due) begin
               if (rd_alive) begin
                  live_any_in  = 1'b1;
                  last_live_in = scan_ff;
               end
               queued_in[rd_data_ff.thread] = 1'b0;
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_POP_RD;
            end else begin
               head_wake_in = rd_data_ff.wake;
               state_in     = ST_POP_END;
            end
         end
         ST_POP_END: begin
            head_in  = slot_index(head_ff, scan_ff);
            occ_in   = occ_ff - scan_ff;
            scan_in  = '0;
            state_in = live_any_ff ? ST_REL_RD : ST_EMIT;
         end
         ST_REL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_index(base_ff, scan_ff);
            state_in = ST_REL_CHK;
         end
         ST_REL_CHK: begin
            rsp_item.released_thread = rd_data_ff.thread;
            rsp_item.released_valid  = 1'b1;
            rsp_item.last            = (scan_ff == last_live_ff);
            if (rd_alive) begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  if (scan_ff == last_live_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     scan_in  = scan_ff + CNT_W'(1);
                     state_in = ST_REL_RD;
                  end
               end
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_REL_RD;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tid_ff       <= tid_in;
      tick_ff      <= tick_in;
      alive_ff     <= alive_in;
      base_ff      <= base_in;
      head_wake_ff <= head_wake_in;
      scan_ff      <= scan_in;
      last_live_ff <= last_live_in;
      live_any_ff  <= live_any_in;
      status_ff    <= status_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         occ_ff    <= '0;
         head_ff   <= '0;
         queued_ff <= '0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         head_ff   <= head_in;
         queued_ff <= queued_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_queued_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(queued_ff) == int'(occ_ff))
      else $error("queued thread flags disagree with occupancy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_item.last |=> state_ff == ST_IDLE)
      else $error("engine still busy after last beat");

   a_rel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && state_ff == ST_REL_CHK |-> scan_ff <= last_live_ff)
      else $error("release scan ran past last live entry");

endmodule

`default_nettype wire

[design/swtq_rsp_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module swtq_rsp_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire swtq_pkg::rsp_type in_item,
   output logic                out_valid,
   input  wire                 out_ready,
   output swtq_pkg::rsp_type   out_item
);
   import swtq_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff, item_in;

   // load whenever the register is empty or draining this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign item_in  = (in_ready && in_valid) ? in_item : item_ff;

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

[design/sorted_wake_time_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sleep beat: a refused request goes straight to its result; an insert walks from the tail,
// moving each queued entry with a later wake tick up one slot.
// Tick beat: a check, a read and compare per due entry, then the cut is found and the head
// moved, then the popped entries are read again up to the last live one; one beat per release.
// Ready only while idle, and sink stalls keep the engine busy; the output register lets the
// last result wait. Reset (sync, active high) empties the queue and the output register and idles the sequencer.

module sorted_wake_time_queue_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [55:0]  req_tdata,  // thread_id[3:0], tick_value[35:4], alive_mask[51:36], zeros
   input  wire          req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [47:0]  rsp_tdata,  // status[1:0], released_thread[5:2], released_valid[6],
                                    // count[11:7], is_empty[12], earliest_wake[44:13], zeros
   output logic         rsp_tuser,  // kind
   output logic         rsp_tlast
);
   import swtq_pkg::*;

   req_type req_item;
   rsp_type eng_item;
   rsp_type out_item;
   logic    eng_valid;
   logic    eng_ready;

   // unpack the request beat
   assign req_item.cmd        = cmd_type'(req_tuser);
   assign req_item.thread_id  = req_tdata[3:0];
   assign req_item.tick_value = req_tdata[35:4];
   assign req_item.alive_mask = req_tdata[51:36];

   // sequencer, slot store and the shared compare
   swtq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .rsp_valid (eng_valid),
      .rsp_ready (eng_ready),
      .rsp_item  (eng_item)
   );

   // hold each result until the sink takes it
   swtq_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (eng_valid),
      .in_ready  (eng_ready),
      .in_item   (eng_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // pack the result beat
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;
   assign rsp_tdata = {3'b000,
                       out_item.earliest_wake,
                       out_item.is_empty,
                       out_item.count,
                       out_item.released_valid,
                       out_item.released_thread,
                       out_item.status};

endmodule

`default_nettype wire

[tb/sv/tb_sorted_wake_time_queue_core.sv]
`timescale 1ns / 1ps

module tb_sorted_wake_time_queue_core;
   import swtq_pkg::*;

   localparam int RANDOM_ITEMS   = 220;
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int STALL_LIMIT    = 3000;  // cycles without any accepted beat
   localparam int SETTLE_CYCLES  = 100;   // longest tick walk is well under this
   localparam int OWED_SLOTS     = 64;    // ring of result beats still owed

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;   // thread_id[3:0], tick_value[35:4], alive_mask[51:36], zeros
   logic         req_tuser;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;   // status[1:0], released_thread[5:2], released_valid[6],
                              // count[11:7], is_empty[12], earliest_wake[44:13], zeros
   logic         rsp_tuser;   // kind
   logic         rsp_tlast;

   // Mirror of the sleeper list, sorted by wake tick
   id_type    sleeper_id   [QUEUE_DEPTH];
   tick_type  sleeper_wake [QUEUE_DEPTH];
   int        sleeper_count;

   rsp_type   owed_ring [OWED_SLOTS];  // result beats still owed by the block
   int        owed_head;
   int        owed_tail;
   int        fail_count;
   bit        calm_run;          // suppress random idling on both sides
   int        rsp_hold_request;  // hold-off length handed to the receiver
   int        hold_left;
   int        stall_cycles;

   sorted_wake_time_queue_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic sleeper_alive(id_type id, mask_type mask);
      // ids past the thread count are always dead
      return (id < THREAD_COUNT) ? mask[id] : 1'b0;
   endfunction

   // Stamp the queue summary taken after the whole step
   function automatic rsp_type with_summary(rsp_type beat);
      beat.count         = COUNT_FLD_W'(sleeper_count);
      beat.is_empty      = (sleeper_count == 0);
      beat.earliest_wake = (sleeper_count == 0) ? '0 : sleeper_wake[0];
      return beat;
   endfunction

   // Append one expected beat to the owed ring
   function automatic void owe_beat(rsp_type beat);
      owed_ring[owed_tail % OWED_SLOTS] = beat;
      owed_tail++;
   endfunction

   // Advance the mirror by one accepted request and queue the owed result beats
   function automatic void predict_wake_queue(cmd_type cmd, id_type tid, tick_type tick,
                                              mask_type mask);
      rsp_type    beat;
      rsp_type    burst [QUEUE_DEPTH];
      int         burst_len;
      status_type verdict;
      int         pos;
      int         popped;
      verdict   = STATUS_OK;
      burst_len = 0;
      if (cmd == CMD_SLEEP) begin
         // dead first, then already queued, then full
         if (!sleeper_alive(tid, mask)) begin
            verdict = STATUS_DEAD;
         end else begin
            for (int i = 0; i < sleeper_count; i++) begin
               if (sleeper_id[i] == tid) verdict = STATUS_QUEUED;
            end
            if (verdict == STATUS_OK && sleeper_count >= QUEUE_DEPTH) verdict = STATUS_FULL;
         end
         if (verdict == STATUS_OK) begin
            // insert behind every equal wake tick to keep arrival order
            pos = 0;
            while (pos < sleeper_count && sleeper_wake[pos] <= tick) pos++;
            for (int i = sleeper_count; i > pos; i--) begin
               sleeper_id[i]   = sleeper_id[i-1];
               sleeper_wake[i] = sleeper_wake[i-1];
            end
            sleeper_id[pos]   = tid;
            sleeper_wake[pos] = tick;
            sleeper_count++;
         end
         beat        = '0;
         beat.kind   = KIND_SLEEP;
         beat.status = verdict;
         beat.last   = 1'b1;
         owe_beat(with_summary(beat));
      end else begin
         // pop every due entry; only live threads produce a beat
         popped = 0;
         while (popped < sleeper_count && sleeper_wake[popped] <= tick) begin
            if (sleeper_alive(sleeper_id[popped], mask)) begin
               beat                 = '0;
               beat.kind            = KIND_RELEASE;
               beat.status          = STATUS_OK;
               beat.released_thread = sleeper_id[popped];
               beat.released_valid  = 1'b1;
               burst[burst_len]     = beat;
               burst_len++;
            end
            popped++;
         end
         for (int i = 0; i + popped < sleeper_count; i++) begin
            sleeper_id[i]   = sleeper_id[i+popped];
            sleeper_wake[i] = sleeper_wake[i+popped];
         end
         sleeper_count -= popped;
         if (burst_len == 0) begin
            beat        = '0;
            beat.kind   = KIND_RELEASE;
            beat.status = STATUS_OK;
            burst[0]    = beat;
            burst_len   = 1;
         end
         burst[burst_len-1].last = 1'b1;
         for (int i = 0; i < burst_len; i++) owe_beat(with_summary(burst[i]));
      end
   endfunction

   // Offer one request beat, hold it until accepted, then predict
   task automatic send_beat(cmd_type cmd, id_type tid, tick_type tick, mask_type mask);
      if (!calm_run && $urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, mask, tick, tid};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_wake_queue(cmd, tid, tick, mask);
   endtask

   // Drop valid and wait for every owed result beat
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_tail != owed_head) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Receiver: random idling, long hold-off on request, none during calm runs
   always @(negedge clock) begin
      logic ready_next;
      if (hold_left == 0 && rsp_hold_request > 0) begin
         hold_left        = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else begin
         ready_next = calm_run || ($urandom_range(0, 99) >= 8);
      end
      rsp_tready <= ready_next;
   end

   // Compare each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_tail == owed_head) begin
            $error("result beat with nothing expected: tuser=%0h tdata=%0h tlast=%0b",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = owed_ring[owed_head % OWED_SLOTS];
            owed_head++;
            check_field("kind", want.kind, rsp_tuser);
            check_field("status", want.status, rsp_tdata[1:0]);
            check_field("released_thread", want.released_thread, rsp_tdata[5:2]);
            check_field("released_valid", want.released_valid, rsp_tdata[6]);
            check_field("last", want.last, rsp_tlast);
            check_field("count", want.count, rsp_tdata[11:7]);
            check_field("is_empty", want.is_empty, rsp_tdata[12]);
            check_field("earliest_wake", want.earliest_wake, rsp_tdata[44:13]);
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Tick on an empty queue, at both ends of the tick range
   task automatic test_empty_tick();
      send_beat(CMD_TICK, 4'd0, 32'h0000_0000, 16'h0000);
      send_beat(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // Refusals, tie ordering and filling the list to its depth
   task automatic test_sleep_status();
      tick_type wake;
      send_beat(CMD_SLEEP, 4'd3, 32'd1000, 16'hFFF7);          // dead thread
      send_beat(CMD_SLEEP, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);     // latest possible wake
      send_beat(CMD_SLEEP, 4'd0, 32'd50, 16'hFFFF);            // already queued
      for (int t = 1; t < 16; t++) begin
         // ties at 100 and 300, a descending run in between, one at tick zero
         if (t < 5) wake = 32'd100;
         else if (t < 10) wake = tick_type'(200 - t * 10);
         else if (t < 15) wake = 32'd300;
         else wake = 32'd0;
         send_beat(CMD_SLEEP, id_type'(t), wake, 16'hFFFF);
      end
      // list full: queued and dead checks still take precedence
      send_beat(CMD_SLEEP, 4'd5, 32'd7, 16'hFFFF);
      send_beat(CMD_SLEEP, 4'd7, 32'd7, 16'hFF7F);
   endtask

   // Releases in wake order, dead sleepers dropped silently
   task automatic test_tick_release();
      send_beat(CMD_TICK, 4'd0, 32'd99, 16'hFFFF);
      send_beat(CMD_TICK, 4'd0, 32'd150, 16'hFFFB);
      send_beat(CMD_TICK, 4'd0, 32'd300, 16'h0000);            // only dead threads due
      send_beat(CMD_TICK, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // Hold the receiver off while the sender keeps offering, then a full release
   task automatic test_output_backpressure();
      wait_drained();
      rsp_hold_request = HOLD_CYCLES;
      for (int t = 0; t < 16; t++) begin
         send_beat(CMD_SLEEP, id_type'(t), tick_type'(500 + (t * 7) % 16), 16'hFFFF);
      end
      send_beat(CMD_TICK, 4'd9, 32'd1000, 16'hFFFF);           // every thread released
      wait_drained();
   endtask

   // Mostly well-formed sleep/tick traffic around a moving clock, with noise
   task automatic test_random_traffic();
      tick_type now_tick;
      tick_type tick;
      id_type   tid;
      mask_type mask;
      cmd_type  cmd;
      int       sleep_pct;
      now_tick = tick_type'($urandom_range(0, 1000));
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) begin
            // move to the top of the tick range, wrap included
            wait_drained();
            now_tick = 32'hFFFF_FE00;
         end else if (k % 64 == 63) begin
            wait_drained();
         end
         calm_run  = (k >= 100 && k < 160);
         sleep_pct = ((k / 40) % 2 != 0) ? 80 : 50;
         tid       = id_type'($urandom);
         mask      = mask_type'($urandom) | mask_type'($urandom);
         if ($urandom_range(0, 99) < 10) begin
            cmd  = cmd_type'($urandom_range(0, 1));
            tick = tick_type'($urandom);
            mask = mask_type'($urandom);
         end else if ($urandom_range(0, 99) < sleep_pct) begin
            cmd  = CMD_SLEEP;
            tick = now_tick + tick_type'($urandom_range(0, 40));
            if ($urandom_range(0, 9) != 0) mask[tid] = 1'b1;
         end else begin
            cmd      = CMD_TICK;
            now_tick = now_tick + tick_type'($urandom_range(0, 25));
            tick     = now_tick;
         end
         send_beat(cmd, tid, tick, mask);
      end
      calm_run = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = 1'b0;
      sleeper_count    = 0;
      owed_head        = 0;
      owed_tail        = 0;
      fail_count       = 0;
      calm_run         = 1'b0;
      rsp_hold_request = 0;
      hold_left        = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_tick();
      test_sleep_status();
      test_tick_release();
      test_output_backpressure();
      test_random_traffic();

      // drain, then give any stray beat time to show up
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
